// ===== hw/rtl/czi_pkg.sv =====
package czi_pkg;

    localparam int MAX_SIDE = 512;
    localparam int MAX_COLS = 1024;

    // Widths fixed by the register and field definitions.
    localparam int PIX_W  = 8;
    localparam int COL_W  = 11;
    localparam int CNT_W  = 10;
    localparam int OUT_W  = 10;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Window coordinates and line buffer index.
    localparam int POS_W = $clog2(MAX_SIDE);

    // Effective column limit of one image row.
    localparam int COL_CAP = (MAX_COLS < 1024) ? MAX_COLS : 1024;

    // Job queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);

    localparam int N_PH = 4;

    typedef enum logic [1:0] {
        REG_COLS  = 2'd0,
        REG_TOP   = 2'd1,
        REG_LEFT  = 2'd2,
        REG_SIDE  = 2'd3
    } t_reg;

    // Results of one window pixel, in emission order.
    typedef enum logic [1:0] {
        PH_DIAG   = 2'd0,
        PH_VERT   = 2'd1,
        PH_HORIZ  = 2'd2,
        PH_CENTER = 2'd3
    } t_phase;

    typedef struct packed {
        logic [COL_W-1:0] cols;
        logic [CNT_W-1:0] top;
        logic [CNT_W-1:0] left;
        logic [CNT_W-1:0] side;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0] r;
        logic [POS_W-1:0] c;
        logic             has_r;
        logic             has_c;
        logic             fend;
        logic [PIX_W-1:0] diag;
        logic [PIX_W-1:0] vert;
        logic [PIX_W-1:0] horiz;
        logic [PIX_W-1:0] center;
    } t_job;

    function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b} + (PIX_W+1)'(1);
        return s[PIX_W:1];
    endfunction

endpackage

// ===== hw/rtl/czi_cfg.sv =====
module czi_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [czi_pkg::ADDR_W-1:0]   paddr,
    input  logic [czi_pkg::DATA_W-1:0]   pwdata,
    output logic [czi_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output czi_pkg::t_cfg                o_cfg
);

    czi_pkg::t_cfg r_cfg;
    czi_pkg::t_reg reg_sel;
    logic          wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = czi_pkg::t_reg'(paddr[3:2]);
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cols <= czi_pkg::COL_W'(1);
            r_cfg.top  <= '0;
            r_cfg.left <= '0;
            r_cfg.side <= czi_pkg::CNT_W'(2);
        end else if (wr_en) begin
            unique case (reg_sel)
                czi_pkg::REG_COLS: r_cfg.cols <= pwdata[czi_pkg::COL_W-1:0];
                czi_pkg::REG_TOP:  r_cfg.top  <= pwdata[czi_pkg::CNT_W-1:0];
                czi_pkg::REG_LEFT: r_cfg.left <= pwdata[czi_pkg::CNT_W-1:0];
                czi_pkg::REG_SIDE: r_cfg.side <= pwdata[czi_pkg::CNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            czi_pkg::REG_COLS: prdata = czi_pkg::DATA_W'(r_cfg.cols);
            czi_pkg::REG_TOP:  prdata = czi_pkg::DATA_W'(r_cfg.top);
            czi_pkg::REG_LEFT: prdata = czi_pkg::DATA_W'(r_cfg.left);
            czi_pkg::REG_SIDE: prdata = czi_pkg::DATA_W'(r_cfg.side);
        endcase
    end

endmodule

// ===== hw/rtl/czi_front.sv =====
module czi_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  czi_pkg::t_cfg               i_cfg,
    input  logic                        i_push,
    input  logic [czi_pkg::PIX_W-1:0]   i_pixel,
    input  logic                        i_frame_start,
    output logic                        o_full,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output czi_pkg::t_job               o_job
);

    // Image position counters.
    logic [czi_pkg::CNT_W-1:0] r_row;
    logic [czi_pkg::CNT_W-1:0] r_col;
    logic [czi_pkg::CNT_W-1:0] n_row;
    logic [czi_pkg::CNT_W-1:0] n_col;

    // Line buffer holding the previous window row.
    logic [czi_pkg::PIX_W-1:0] mem [czi_pkg::MAX_SIDE];
    logic [czi_pkg::PIX_W-1:0] r_above;

    // Neighbor pixels of the running window row.
    logic [czi_pkg::PIX_W-1:0] r_left;
    logic [czi_pkg::PIX_W-1:0] r_ul;

    // Classified stage.
    logic                      r_s1_valid;
    logic [czi_pkg::PIX_W-1:0] r_s1_pix;
    logic [czi_pkg::PIX_W-1:0] r_s1_left;
    logic [czi_pkg::POS_W-1:0] r_s1_r;
    logic [czi_pkg::POS_W-1:0] r_s1_c;
    logic                      r_s1_fend;

    logic [czi_pkg::COL_W-1:0] cols_eff;
    logic [czi_pkg::CNT_W-1:0] side_eff;
    logic [czi_pkg::CNT_W-1:0] side_m1;
    logic [czi_pkg::CNT_W-1:0] ri;
    logic [czi_pkg::CNT_W-1:0] ci;
    logic [czi_pkg::COL_W-1:0] ci_inc;
    logic [czi_pkg::CNT_W-1:0] row_off;
    logic [czi_pkg::CNT_W-1:0] col_off;
    logic [czi_pkg::POS_W-1:0] pos_r;
    logic [czi_pkg::POS_W-1:0] pos_c;
    logic                      wrap;
    logic                      in_win;
    logic                      fend;
    logic                      accept;
    logic                      win_acc;
    logic                      s1_fire;
    logic [czi_pkg::PIX_W-1:0] upper;
    logic [czi_pkg::PIX_W-1:0] lower;

    always_comb begin
        if (i_cfg.cols == '0) begin
            cols_eff = czi_pkg::COL_W'(1);
        end else if (i_cfg.cols > czi_pkg::COL_W'(czi_pkg::COL_CAP)) begin
            cols_eff = czi_pkg::COL_W'(czi_pkg::COL_CAP);
        end else begin
            cols_eff = i_cfg.cols;
        end

        if (i_cfg.side > czi_pkg::CNT_W'(czi_pkg::MAX_SIDE)) begin
            side_eff = czi_pkg::CNT_W'(czi_pkg::MAX_SIDE);
        end else begin
            side_eff = i_cfg.side;
        end
        side_m1 = side_eff - czi_pkg::CNT_W'(1);

        ri = i_frame_start ? '0 : r_row;
        ci = i_frame_start ? '0 : r_col;

        ci_inc = {1'b0, ci} + czi_pkg::COL_W'(1);
        wrap   = (ci_inc >= cols_eff);
        n_col  = wrap ? '0 : ci_inc[czi_pkg::CNT_W-1:0];
        n_row  = wrap ? ri + czi_pkg::CNT_W'(1) : ri;

        row_off = ri - i_cfg.top;
        col_off = ci - i_cfg.left;
        in_win  = (ri >= i_cfg.top) && (row_off < side_eff)
               && (ci >= i_cfg.left) && (col_off < side_eff);
        pos_r   = row_off[czi_pkg::POS_W-1:0];
        pos_c   = col_off[czi_pkg::POS_W-1:0];
        fend    = (czi_pkg::CNT_W'(pos_r) == side_m1)
               && (czi_pkg::CNT_W'(pos_c) == side_m1);
    end

    assign s1_fire  = r_s1_valid && !i_q_full;
    assign o_full   = r_s1_valid && i_q_full;
    assign accept   = i_push && !o_full;
    assign win_acc  = accept && in_win;
    assign o_q_push = s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Read comes before write, so a pixel sees the entry of the row above
    // even when the previous item wrote the same column.
    always_ff @(posedge i_clk) begin
        if (win_acc) begin
            r_above     <= mem[pos_c];
            mem[pos_c]  <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_left     <= '0;
            r_ul       <= '0;
        end else begin
            if (win_acc) begin
                r_s1_valid <= 1'b1;
                r_left     <= i_pixel;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_ul <= r_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_acc) begin
            r_s1_pix  <= i_pixel;
            r_s1_left <= r_left;
            r_s1_r    <= pos_r;
            r_s1_c    <= pos_c;
            r_s1_fend <= fend;
        end
    end

    always_comb begin
        upper        = czi_pkg::avg2(r_ul, r_above);
        lower        = czi_pkg::avg2(r_s1_left, r_s1_pix);
        o_job.r      = r_s1_r;
        o_job.c      = r_s1_c;
        o_job.has_r  = (r_s1_r != '0);
        o_job.has_c  = (r_s1_c != '0);
        o_job.fend   = r_s1_fend;
        o_job.diag   = czi_pkg::avg2(upper, lower);
        o_job.vert   = czi_pkg::avg2(r_above, r_s1_pix);
        o_job.horiz  = lower;
        o_job.center = r_s1_pix;
    end

endmodule

// ===== hw/rtl/czi_queue.sv =====
module czi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  czi_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output czi_pkg::t_job o_job
);

    czi_pkg::t_job                r_mem [czi_pkg::Q_DEPTH];
    logic [czi_pkg::QP_W-1:0]     r_wptr;
    logic [czi_pkg::QP_W-1:0]     r_rptr;
    logic [czi_pkg::QP_W:0]       r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_count == (czi_pkg::QP_W+1)'(czi_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + czi_pkg::QP_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + czi_pkg::QP_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (czi_pkg::QP_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (czi_pkg::QP_W+1)'(1);
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (czi_pkg::QP_W+1)'(czi_pkg::Q_DEPTH))
        else $error("job queue count out of range");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr - r_rptr) == r_count[czi_pkg::QP_W-1:0])
        else $error("job queue pointers disagree with count");

endmodule

// ===== hw/rtl/czi_back.sv =====
module czi_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  czi_pkg::t_job               i_job,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [czi_pkg::OUT_W-1:0]   o_out_row,
    output logic [czi_pkg::OUT_W-1:0]   o_out_col,
    output logic [czi_pkg::PIX_W-1:0]   o_value,
    output logic                        o_last,
    output logic                        o_frame_end
);

    logic                        r_out_valid;
    logic [czi_pkg::OUT_W-1:0]   r_out_row;
    logic [czi_pkg::OUT_W-1:0]   r_out_col;
    logic [czi_pkg::PIX_W-1:0]   r_value;
    logic                        r_last;
    logic                        r_fend;
    logic [czi_pkg::N_PH-1:0]    r_done;

    logic                        head_valid;
    logic [czi_pkg::N_PH-1:0]    exist;
    logic [czi_pkg::N_PH-1:0]    pending;
    logic [czi_pkg::N_PH-1:0]    sel_oh;
    czi_pkg::t_phase             sel;
    logic                        is_last;
    logic                        load;
    logic [czi_pkg::OUT_W-1:0]   row2;
    logic [czi_pkg::OUT_W-1:0]   col2;
    logic [czi_pkg::OUT_W-1:0]   n_out_row;
    logic [czi_pkg::OUT_W-1:0]   n_out_col;
    logic [czi_pkg::PIX_W-1:0]   n_value;

    assign head_valid = !i_q_empty;

    always_comb begin
        exist                     = '0;
        exist[czi_pkg::PH_DIAG]   = i_job.has_r && i_job.has_c;
        exist[czi_pkg::PH_VERT]   = i_job.has_r;
        exist[czi_pkg::PH_HORIZ]  = i_job.has_c;
        exist[czi_pkg::PH_CENTER] = 1'b1;
        pending = exist & ~r_done;

        priority if (pending[czi_pkg::PH_DIAG]) begin
            sel = czi_pkg::PH_DIAG;
        end else if (pending[czi_pkg::PH_VERT]) begin
            sel = czi_pkg::PH_VERT;
        end else if (pending[czi_pkg::PH_HORIZ]) begin
            sel = czi_pkg::PH_HORIZ;
        end else begin
            sel = czi_pkg::PH_CENTER;
        end

        sel_oh  = czi_pkg::N_PH'(1) << sel;
        is_last = (sel == czi_pkg::PH_CENTER);
        row2    = {i_job.r, 1'b0};
        col2    = {i_job.c, 1'b0};

        unique case (sel)
            czi_pkg::PH_DIAG: begin
                n_out_row = row2 - czi_pkg::OUT_W'(1);
                n_out_col = col2 - czi_pkg::OUT_W'(1);
                n_value   = i_job.diag;
            end
            czi_pkg::PH_VERT: begin
                n_out_row = row2 - czi_pkg::OUT_W'(1);
                n_out_col = col2;
                n_value   = i_job.vert;
            end
            czi_pkg::PH_HORIZ: begin
                n_out_row = row2;
                n_out_col = col2 - czi_pkg::OUT_W'(1);
                n_value   = i_job.horiz;
            end
            czi_pkg::PH_CENTER: begin
                n_out_row = row2;
                n_out_col = col2;
                n_value   = i_job.center;
            end
        endcase
    end

    assign load    = head_valid && (!r_out_valid || i_pop);
    assign o_q_pop = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_done      <= is_last ? '0 : (r_done | sel_oh);
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_value   <= n_value;
            r_last    <= is_last;
            r_fend    <= is_last && i_job.fend;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_value     = r_value;
    assign o_last      = r_last;
    assign o_frame_end = r_fend;

    a_done_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done != '0) |-> head_valid)
        else $error("emitted-result mask set with no job at the queue head");

    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_valid |-> ((r_done & ~exist) == '0) && !r_done[czi_pkg::PH_CENTER])
        else $error("emitted-result mask marks a result the job does not have");

    a_pop_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_out_valid && r_last))
        else $error("job retired without its last result in the output register");

endmodule

// ===== hw/rtl/crop_and_zoom_2x_interpolate_top.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         push / full               i_pixel, i_frame_start
// result    out        pop / empty               o_out_row, o_out_col, o_value,
//                                                o_last, o_frame_end
// config    in/out     psel, penable, pwrite,    paddr, pwdata, prdata
//                      pready
//
// A pixel is taken when full is low; one outside the window only advances the counters.
// A window pixel yields one to four results, one per cycle from the output register while
// results are popped, so the sustained rate is set by the result port.
// The front classifies a pixel and reads the 512 x 8 line buffer in the cycle it is
// taken; a four-entry job queue lets the front run ahead while results wait to be popped.
// Reset is synchronous, active low: counters, queue, output and registers are cleared;
// the line buffer is not cleared and holds nothing valid until its rows are written.
module crop_and_zoom_2x_interpolate_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [czi_pkg::PIX_W-1:0]   i_pixel,
    input  logic                        i_frame_start,
    output logic                        empty,
    input  logic                        pop,
    output logic [czi_pkg::OUT_W-1:0]   o_out_row,
    output logic [czi_pkg::OUT_W-1:0]   o_out_col,
    output logic [czi_pkg::PIX_W-1:0]   o_value,
    output logic                        o_last,
    output logic                        o_frame_end,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [czi_pkg::ADDR_W-1:0]  paddr,
    input  logic [czi_pkg::DATA_W-1:0]  pwdata,
    output logic [czi_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    czi_pkg::t_cfg cfg;
    czi_pkg::t_job front_job;
    czi_pkg::t_job head_job;
    logic          q_push;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    czi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    czi_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_push        (push),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_full        (full),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_job         (front_job)
    );

    czi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_job   (head_job)
    );

    czi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_value     (o_value),
        .o_last      (o_last),
        .o_frame_end (o_frame_end)
    );

endmodule
